[sv/sinusoidal_iteration_colorizer_unit_defines.svh]
// Assertion macros shared by the colorizer RTL.
`ifndef SINUSOIDAL_ITERATION_COLORIZER_UNIT_DEFINES_SVH
`define SINUSOIDAL_ITERATION_COLORIZER_UNIT_DEFINES_SVH

// Check that an antecedent is always followed by a consequent sequence.
`define SICU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("colorizer assertion failed");

// Check that a condition never occurs.
`define SICU_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("colorizer assertion failed");

`endif

[sv/sicu_pkg.sv]
// Package: constants, types and the sine sample function of the colorizer.
package sicu_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam logic [15:0] LIMIT_RESET = 16'd100;
    localparam int COUNT_W = 32;
    localparam int LIMIT_W = 16;
    localparam int T_W     = 16;
    localparam int RAD_W   = 21;
    localparam int TURN_W  = 32;
    localparam int MAG_W   = 17;
    localparam int LAT_DIV = 17;
    localparam int TAIL_STAGES = 7;

    localparam logic [29:0] RAD_TO_TURN = 30'd683565276;
    localparam logic [RAD_W-1:0] OFS_GREEN = 21'd137232;
    localparam logic [RAD_W-1:0] OFS_BLUE  = 21'd274465;
    localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [7:0] ALPHA = 8'hFF;
    localparam logic [31:0] BLACK = 32'h0000_00FF;

    typedef struct packed {
        logic valid;
        logic black;
    } sicu_ctl_t;

    // Rounded Q16 sine magnitude at quarter-wave position pos of 2**qb.
    function automatic logic [MAG_W-1:0] sine_mag(input int qb, input int pos);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned m;
        longint unsigned s;
        x  = longint'(pos) << (30 - qb);
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((p * x2) >> 30);
        p  = 64'd85569306   - ((p * x2) >> 30);
        p  = 64'd693598668  - ((p * x2) >> 30);
        p  = 64'd1686629713 - ((p * x2) >> 30);
        m  = (p * x) >> 30;
        s  = (m + 64'd8192) >> 14;
        if (s > 64'd65536)
        begin
            s = 64'd65536;
        end
        return s[MAG_W-1:0];
    endfunction

endpackage

[sv/sicu_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
module sicu_div
    import sicu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [COUNT_W-1:0] count,
    input  logic [LIMIT_W-1:0] limit,
    output sicu_ctl_t          ctl_out,
    output logic [T_W-1:0]     quot
);

    localparam int NS = T_W + 1;

    sicu_ctl_t          ctl_reg  [NS];
    logic [LIMIT_W-1:0] rem_reg  [NS];
    logic [T_W-1:0]     low_reg  [NS];
    logic [T_W-1:0]     quot_reg [NS];

    // Entry stage: black test at full width, seed the remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0].valid <= in_valid;
            ctl_reg[0].black <= (count[COUNT_W-1:T_W] >= limit);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= count[COUNT_W-1:T_W];
        low_reg[0]  <= count[T_W-1:0];
        quot_reg[0] <= '0;
    end

    for (genvar k = 0; k < T_W; k++)
    begin : g_stage
        logic [LIMIT_W:0]   trial;
        logic               ge;
        logic [LIMIT_W:0]   diff;
        logic [LIMIT_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][T_W-1]};
            ge       = (trial >= {1'b0, limit});
            diff     = trial - {1'b0, limit};
            rem_next = ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            low_reg[k+1]  <= {low_reg[k][T_W-2:0], 1'b0};
            quot_reg[k+1] <= {quot_reg[k][T_W-2:0], ge};
        end
    end

    assign ctl_out = ctl_reg[NS-1];
    assign quot    = quot_reg[NS-1];

endmodule

[sv/sicu_lane.sv]
// One color channel: sine lookups, wave level, brightness scale and clamp.
module sicu_lane
    import sicu_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic              clk,
    input  logic [TURN_W-1:0] wave_turns,
    input  logic [TURN_W-1:0] bright_turns,
    output logic [7:0]        level_out
);

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam int QN = 1 << QB;

    logic [MAG_W-1:0] lut [QN+1];

    for (genvar i = 0; i <= QN; i++)
    begin : g_lut
        assign lut[i] = sine_mag(QB, i);
    end

    logic [TURN_W-1:0] turns [2];
    logic [MAG_W-1:0]  mag   [2];
    logic              neg   [2];

    assign turns[0] = wave_turns;
    assign turns[1] = bright_turns;

    // Quadrant select and mirror, then read the quarter-wave table.
    for (genvar j = 0; j < 2; j++)
    begin : g_look
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [QB:0]                pos;
        always_comb
        begin
            idx = turns[j][TURN_W-1 -: SINE_TABLE_BITS];
            pos = {1'b0, idx[QB-1:0]};
            if (idx[QB])
            begin
                pos = QN[QB:0] - pos;
            end
            mag[j] = lut[pos];
            neg[j] = idx[QB+1];
        end
    end

    logic [MAG_W-1:0] sw_reg;
    logic [MAG_W-1:0] sb_reg;
    logic             nw_reg;
    logic             nb_reg;
    logic [7:0]       level_reg;
    logic [18:0]      num_reg;
    logic [26:0]      prod_reg;
    logic [7:0]       out_reg;

    logic [17:0] wv;
    logic [25:0] wprod;
    logic [7:0]  level_next;
    logic [18:0] num_next;
    logic [10:0] scaled;
    logic [26:0] recip;
    logic [8:0]  quo;
    logic [7:0]  out_next;

    always_comb
    begin
        wv         = nw_reg ? (18'd65536 - {1'b0, sw_reg}) : (18'd65536 + {1'b0, sw_reg});
        wprod      = {8'd0, wv} * 26'd255;
        level_next = wprod[24:17];
        num_next   = nb_reg ? (19'd262144 - {2'b0, sb_reg}) : (19'd262144 + {2'b0, sb_reg});
        // Divide by 327680: drop 16 bits, then divide by 5 via reciprocal.
        scaled     = prod_reg[26:16];
        recip      = {16'd0, scaled} * 27'd52429;
        quo        = recip[26:18];
        out_next   = (quo > 9'd255) ? 8'hFF : quo[7:0];
    end

    always_ff @(posedge clk)
    begin
        sw_reg    <= mag[0];
        nw_reg    <= neg[0];
        sb_reg    <= mag[1];
        nb_reg    <= neg[1];
        level_reg <= level_next;
        num_reg   <= num_next;
        prod_reg  <= {19'd0, level_reg} * {8'd0, num_reg};
        out_reg   <= out_next;
    end

    assign level_out = out_reg;

endmodule

[sv/sinusoidal_iteration_colorizer_unit.sv]
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// The latency is set by the 17-stage divider and 7 tail stages, all free running.
// Reset (rst_n, async, active low) clears all valid bits and sets the limit to 100.
// The receiver cannot stall: every result shows on done for exactly one cycle.
module sinusoidal_iteration_colorizer_unit
    import sicu_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COUNT_W-1:0] smooth_count,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    output logic               done,
    output logic [31:0]        pixel_color
);

`include "sinusoidal_iteration_colorizer_unit_defines.svh"

    // The configuration register; the user must change it only while no transaction is in flight (not enforced here).
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Never hold off a transaction.
    assign busy = 1'b0;

    sicu_ctl_t      div_ctl;
    logic [T_W-1:0] t_val;

    // Divide count by limit to get t in Q0.16, one bit per stage.
    sicu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .count    (smooth_count),
        .limit    (limit_reg),
        .ctl_out  (div_ctl),
        .quot     (t_val)
    );

    // Control follows the data through the tail stages.
    sicu_ctl_t ctl_reg [TAIL_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAIL_STAGES; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= div_ctl;
            for (int i = 1; i < TAIL_STAGES; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Angle stage: phases and brightness angles in Q16.16 radians.
    logic [RAD_W-1:0] ang_reg [6];
    logic [RAD_W-1:0] t_ext;

    assign t_ext = {5'd0, t_val};

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= t_ext * 21'd15;
        ang_reg[1] <= t_ext * 21'd15 + OFS_GREEN;
        ang_reg[2] <= t_ext * 21'd15 + OFS_BLUE;
        ang_reg[3] <= t_ext * 21'd5;
        ang_reg[4] <= t_ext * 21'd7;
        ang_reg[5] <= t_ext * 21'd11;
    end

    // Turn stage: radians to a 32-bit fraction of a turn, one multiplier each.
    logic [TURN_W-1:0] turn_reg [6];

    for (genvar a = 0; a < 6; a++)
    begin : g_turn
        logic [50:0] prod;
        assign prod = {30'd0, ang_reg[a]} * {21'd0, RAD_TO_TURN};
        always_ff @(posedge clk)
        begin
            if (a == 4)
            begin
                // Green brightness uses the cosine: advance a quarter turn.
                turn_reg[a] <= prod[47:16] + QUARTER_TURN;
            end
            else
            begin
                turn_reg[a] <= prod[47:16];
            end
        end
    end

    logic [7:0] chan [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        sicu_lane #(
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
        ) u_lane (
            .clk          (clk),
            .wave_turns   (turn_reg[c]),
            .bright_turns (turn_reg[c+3]),
            .level_out    (chan[c])
        );
    end

    // Output register: drop in black for counts at or above the limit.
    logic [31:0] color_reg;
    logic [31:0] color_next;

    assign color_next = ctl_reg[TAIL_STAGES-2].black ? BLACK
                                                     : {chan[0], chan[1], chan[2], ALPHA};

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign done        = ctl_reg[TAIL_STAGES-1].valid;
    assign pixel_color = color_reg;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY = LAT_DIV + TAIL_STAGES;

    // A transaction accepted at or above the limit.
    logic in_black;

    assign in_black = start && (smooth_count[COUNT_W-1:T_W] >= limit_reg);

    `SICU_ASSERT_IMPL(a_latency, done, $past(start, LATENCY))
    `SICU_ASSERT_IMPL(a_black, in_black, ##LATENCY (done && (pixel_color == BLACK)))

endmodule

[dv/tb.sv]
// Self-checking testbench for the sinusoidal iteration colorizer unit.
module tb;
    import sicu_pkg::*;

    localparam int STB = SINE_TABLE_BITS_DEF;
    localparam int SETTLE_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [COUNT_W-1:0] smooth_count = '0;
    logic               cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               done;
    logic [31:0]        pixel_color;

    // Shadow of the limit register as the predictor sees it.
    logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;
    // Colors owed by the block, oldest first.
    logic [31:0]        pending_colors[$];
    int                 mismatches = 0;
    int                 burst_left = 0;

    sinusoidal_iteration_colorizer_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .smooth_count (smooth_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .pixel_color  (pixel_color)
    );

    always #5 clk = ~clk;

    // Scale Q16.16 radians to a 32-bit fraction of a turn.
    function automatic logic [31:0] rad_to_turns(input longint unsigned rad);
        longint unsigned prod;
        prod = (rad * 64'd683565276) >> 16;
        return prod[31:0];
    endfunction

    // Sampled sine: Q16 magnitude plus sign from the quadrant.
    function automatic logic [16:0] sampled_sine(input logic [31:0] turns, output bit neg);
        logic [STB-1:0]  idx;
        logic [1:0]      quad;
        longint unsigned pos;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned poly;
        longint unsigned mag;
        idx  = turns[31 -: STB];
        quad = idx[STB-1 -: 2];
        pos  = idx[STB-3:0];
        if (quad[0])
        begin
            pos = (64'd1 << (STB - 2)) - pos;
        end
        x    = pos << (30 - (STB - 2));
        x2   = (x * x) >> 30;
        poly = 64'd172272;
        poly = 64'd5026995    - ((poly * x2) >> 30);
        poly = 64'd85569306   - ((poly * x2) >> 30);
        poly = 64'd693598668  - ((poly * x2) >> 30);
        poly = 64'd1686629713 - ((poly * x2) >> 30);
        mag  = (((poly * x) >> 30) + 64'd8192) >> 14;
        if (mag > 64'd65536)
        begin
            mag = 64'd65536;
        end
        neg = quad[1];
        return mag[16:0];
    endfunction

    // Channel level from the color wave, then scaled by the brightness wave.
    function automatic logic [7:0] channel_value(input logic [31:0] wave_turns,
                                                 input logic [31:0] bright_turns);
        bit              neg;
        longint unsigned s;
        longint unsigned lvl;
        longint unsigned num;
        longint unsigned val;
        s   = sampled_sine(wave_turns, neg);
        lvl = neg ? (64'd255 * 65536 - 64'd255 * s) : (64'd255 * 65536 + 64'd255 * s);
        lvl = lvl >> 17;
        s   = sampled_sine(bright_turns, neg);
        num = neg ? (64'd262144 - s) : (64'd262144 + s);
        val = (lvl * num) / 64'd327680;
        if (val > 64'd255)
        begin
            val = 64'd255;
        end
        return val[7:0];
    endfunction

    function automatic logic [31:0] predict_color(input logic [31:0] count,
                                                  input logic [15:0] limit);
        longint unsigned t;
        longint unsigned phase;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        if (longint'(count) >= (longint'(limit) << 16))
        begin
            return BLACK;
        end
        t     = longint'(count) / longint'(limit);
        phase = t * 15;
        red   = channel_value(rad_to_turns(phase), rad_to_turns(t * 5));
        green = channel_value(rad_to_turns(phase + 64'd137232),
                              rad_to_turns(t * 7) + QUARTER_TURN);
        blue  = channel_value(rad_to_turns(phase + 64'd274465), rad_to_turns(t * 11));
        return {red, green, blue, ALPHA};
    endfunction

    // Compare every strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && done)
        begin
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pixel_color=%h", pixel_color);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (pixel_color !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel_color mismatch: expected %h actual %h", want, pixel_color);
                end
            end
        end
    end

    // Send one count; bursts of back-to-back transactions with random gaps.
    task automatic send_pixel(input logic [31:0] count);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        start        <= 1'b1;
        smooth_count <= count;
        do @(posedge clk); while (busy);
        pending_colors.push_back(predict_color(count, limit_shadow));
        burst_left--;
    endtask

    // Drop start and wait until every owed color has come back.
    task automatic drain;
        @(negedge clk);
        start      <= 1'b0;
        burst_left = 0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the limit register while the pipeline is empty.
    task automatic set_limit(input logic [15:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow = value;
    endtask

    // Random count: mostly inside the colored range, some at or past the limit.
    function automatic logic [31:0] random_count(input logic [15:0] limit);
        longint unsigned top;
        top = (longint'(limit) << 16);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(top);
            default: return (top == 0) ? $urandom() : 32'($urandom_range(0, 32'(top - 1)));
        endcase
    endfunction

    task automatic test_default_limit;
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0001);
        send_pixel(32'h0001_0000);
        send_pixel((32'd100 << 16) - 1);
        send_pixel(32'd100 << 16);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8000_0000);
        send_pixel(32'h0032_8000);
    endtask

    task automatic test_limit_extremes;
        set_limit(16'd1);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0001_0000);
        send_pixel(32'h0000_8000);
        set_limit(16'hFFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFE_FFFF);
        send_pixel(32'hFFFF_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5555_AAAA);
        // Zero limit: every count must come back black.
        set_limit(16'd0);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1234_5678);
        send_pixel(32'hFFFF_FFFF);
    endtask

    task automatic test_random_sweep;
        logic [15:0] limit;
        for (int phase_idx = 0; phase_idx < 8; phase_idx++)
        begin
            case (phase_idx)
                0: limit = 16'd1;
                1: limit = 16'hFFFF;
                2: limit = 16'd100;
                default: limit = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 1000))
                                                             : 16'($urandom_range(1, 65535));
            endcase
            set_limit(limit);
            repeat (200) send_pixel(random_count(limit));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_limit();
        test_limit_extremes();
        test_random_sweep();
        drain();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
